### sv/pnpb_pkg.sv
// shared types, constants and tables for the polar nearest point binner
// no dependencies
`timescale 1ns / 1ps

package pnpb_pkg;

   // bin count and derived widths
   localparam int BINS       = 360;
   localparam int BIN_W      = $clog2(BINS);
   localparam int Q_W        = $clog2(BINS + 1);

   // angles in 1/256 degree, Z_MAX in 2^-16 degree
   localparam int FULL_TURN    = 360 * 256;
   localparam int HALF_TURN    = 180 * 256;
   localparam int QUARTER_TURN = 90 * 256;
   localparam int Z_MAX        = 90 * 65536;

   // cordic sizing
   localparam int STEPS    = 20;
   localparam int SQRT_STEPS = 16;
   localparam int PRESHIFT = 24;
   localparam int CW       = 44;
   localparam int ZW       = 25;

   // bin scaling: n = full * BINS + HALF_TURN / 2, q = n / FULL_TURN by reciprocal
   localparam int N_W    = $clog2(FULL_TURN * BINS);
   localparam int DIV_SH = N_W + 17;
   localparam logic [63:0] DIV_M = (64'd1 << DIV_SH) / 64'(FULL_TURN) + 64'd1;
   localparam logic [N_W-1:0] ROUND_OFS = N_W'(HALF_TURN / 2);

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_READ   = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      CSR_MIN_RANGE = 1'b0,
      CSR_MAX_RANGE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic [8:0]         bin_index;
   } req_type;

   typedef struct packed {
      logic signed [15:0] read_x;
      logic signed [15:0] read_y;
      logic [15:0]        read_distance;
      logic               read_valid;
   } rsp_type;

   // one bin as stored in memory
   typedef struct packed {
      logic        filled;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] range;
   } entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SQUARE,
      ST_LOAD,
      ST_ITER,
      ST_ANGLE,
      ST_SCALE,
      ST_DIVIDE,
      ST_INS_RD,
      ST_INS_WR,
      ST_BIN_RD,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic square;
      logic load;
      logic iterate;
      logic angle;
      logic scale;
      logic divide;
      logic ins_read;
      logic ins_write;
      logic bin_read;
      logic clr_step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic iter_done;
      logic clr_done;
   } status_type;

   // atan(2^-i) in 2^-16 degree
   function automatic logic [ZW-1:0] atan_tab(input logic [4:0] i);
      logic [ZW-1:0] v;
      case (i)
         5'd0:    v = ZW'(2949120);
         5'd1:    v = ZW'(1740967);
         5'd2:    v = ZW'(919879);
         5'd3:    v = ZW'(466945);
         5'd4:    v = ZW'(234379);
         5'd5:    v = ZW'(117304);
         5'd6:    v = ZW'(58666);
         5'd7:    v = ZW'(29335);
         5'd8:    v = ZW'(14668);
         5'd9:    v = ZW'(7334);
         5'd10:   v = ZW'(3667);
         5'd11:   v = ZW'(1833);
         5'd12:   v = ZW'(917);
         5'd13:   v = ZW'(458);
         5'd14:   v = ZW'(229);
         5'd15:   v = ZW'(115);
         5'd16:   v = ZW'(57);
         5'd17:   v = ZW'(29);
         5'd18:   v = ZW'(14);
         5'd19:   v = ZW'(7);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### sv/pnpb_ctrl.sv
// controller state machine for the binner
// depends on pnpb_pkg
`timescale 1ns / 1ps

module pnpb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_kind,
   input  pnpb_pkg::status_type status,
   output pnpb_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   pnpb_pkg::state_type state_ff, state_in;

   // state register, reset starts with a clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pnpb_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         pnpb_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_done) state_in = pnpb_pkg::ST_IDLE;
         end
         pnpb_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               unique case (req_kind)
                  pnpb_pkg::KIND_INSERT: state_in = pnpb_pkg::ST_SQUARE;
                  pnpb_pkg::KIND_READ:   state_in = pnpb_pkg::ST_BIN_RD;
                  pnpb_pkg::KIND_CLEAR:  state_in = pnpb_pkg::ST_CLEAR;
                  default:               state_in = pnpb_pkg::ST_IDLE;
               endcase
            end
         end
         pnpb_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = pnpb_pkg::ST_LOAD;
         end
         pnpb_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = pnpb_pkg::ST_ITER;
         end
         pnpb_pkg::ST_ITER: begin
            cmd.iterate = 1'b1;
            if (status.iter_done) state_in = pnpb_pkg::ST_ANGLE;
         end
         pnpb_pkg::ST_ANGLE: begin
            cmd.angle = 1'b1;
            state_in  = pnpb_pkg::ST_SCALE;
         end
         pnpb_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = pnpb_pkg::ST_DIVIDE;
         end
         pnpb_pkg::ST_DIVIDE: begin
            cmd.divide = 1'b1;
            state_in   = pnpb_pkg::ST_INS_RD;
         end
         pnpb_pkg::ST_INS_RD: begin
            cmd.ins_read = 1'b1;
            state_in     = pnpb_pkg::ST_INS_WR;
         end
         pnpb_pkg::ST_INS_WR: begin
            cmd.ins_write = 1'b1;
            state_in      = pnpb_pkg::ST_IDLE;
         end
         pnpb_pkg::ST_BIN_RD: begin
            cmd.bin_read = 1'b1;
            state_in     = pnpb_pkg::ST_RESP;
         end
         pnpb_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = pnpb_pkg::ST_IDLE;
         end
         default: state_in = pnpb_pkg::ST_IDLE;
      endcase
   end

endmodule

### sv/pnpb_dp.sv
// datapath: cordic bearing, bit-serial root, bin scaling and bin memory
// depends on pnpb_pkg
`timescale 1ns / 1ps

module pnpb_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  pnpb_pkg::req_type    req,
   input  pnpb_pkg::cmd_type    cmd,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [15:0]          csr_wdata,
   output pnpb_pkg::status_type status,
   output pnpb_pkg::rsp_type    rsp
);

   localparam int CW = pnpb_pkg::CW;
   localparam int ZW = pnpb_pkg::ZW;

   // configuration registers
   logic [15:0] min_range_ff, max_range_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff <= 16'd100;
         max_range_ff <= 16'd5000;
      end else if (csr_we) begin
         case (csr_index)
            pnpb_pkg::CSR_MIN_RANGE: min_range_ff <= csr_wdata;
            default:                 max_range_ff <= csr_wdata;
         endcase
      end
   end

   // captured item
   logic [15:0] x_ff, y_ff;
   logic [16:0] ax_ff, ay_ff;
   logic [8:0]  bidx_ff;
   logic signed [16:0] xs, ys;
   assign xs = {req.point_x[15], req.point_x};
   assign ys = {req.point_y[15], req.point_y};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff    <= req.point_x;
         y_ff    <= req.point_y;
         ax_ff   <= req.point_x[15] ? 17'(-xs) : 17'(xs);
         ay_ff   <= req.point_y[15] ? 17'(-ys) : 17'(ys);
         bidx_ff <= req.bin_index;
      end
   end

   // squares for the range
   logic [30:0] sqx_ff, sqy_ff;
   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sqx_ff <= 31'(ax_ff * ax_ff);
         sqy_ff <= 31'(ay_ff * ay_ff);
      end
   end

   // cordic vectoring, one step per cycle
   logic signed [CW-1:0] cx_ff, cy_ff, dx, dy;
   logic signed [ZW-1:0] z_ff, zt;
   logic [4:0]           step_ff;

   assign dx = cy_ff >>> step_ff;
   assign dy = cx_ff >>> step_ff;
   assign zt = $signed(pnpb_pkg::atan_tab(step_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.load) begin
         step_ff <= '0;
      end else if (cmd.iterate) begin
         step_ff <= step_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff <= CW'({ax_ff, 24'd0});
         cy_ff <= CW'({ay_ff, 24'd0});
         z_ff  <= '0;
      end else if (cmd.iterate) begin
         if (cy_ff > 0) begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            z_ff  <= z_ff + zt;
         end else begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            z_ff  <= z_ff - zt;
         end
      end
   end

   assign status.iter_done = (step_ff == 5'(pnpb_pkg::STEPS - 1));

   // restoring square root, two radicand bits per step
   logic [31:0] rad_ff;
   logic [17:0] rem_ff;
   logic [15:0] root_ff;
   logic [19:0] rem_sh, trial;
   assign rem_sh = {rem_ff, rad_ff[31:30]};
   assign trial  = {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rad_ff  <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.iterate && step_ff < 5'(pnpb_pkg::SQRT_STEPS)) begin
         rad_ff <= {rad_ff[29:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= 18'(rem_sh - trial);
            root_ff <= {root_ff[14:0], 1'b1};
         end else begin
            rem_ff  <= 18'(rem_sh);
            root_ff <= {root_ff[14:0], 1'b0};
         end
      end
   end

   // quadrant mapping to full bearing
   logic signed [ZW-1:0] zc;
   logic [14:0] qa;
   logic [17:0] full_c;
   logic [16:0] full_ff;

   always_comb begin
      if (z_ff < 0) begin
         zc = '0;
      end else if (z_ff > ZW'(pnpb_pkg::Z_MAX)) begin
         zc = ZW'(pnpb_pkg::Z_MAX);
      end else begin
         zc = z_ff;
      end
      if (ay_ff == '0) begin
         qa = '0;
      end else if (ax_ff == '0) begin
         qa = 15'(pnpb_pkg::QUARTER_TURN);
      end else begin
         qa = 15'((zc + ZW'(128)) >>> 8);
      end
      if (!x_ff[15] && !y_ff[15]) begin
         full_c = 18'(qa);
      end else if (x_ff[15] && !y_ff[15]) begin
         full_c = 18'(pnpb_pkg::HALF_TURN) - 18'(qa);
      end else if (x_ff[15]) begin
         full_c = 18'(pnpb_pkg::HALF_TURN) + 18'(qa);
      end else begin
         full_c = 18'(pnpb_pkg::FULL_TURN) - 18'(qa);
      end
      if (full_c >= 18'(pnpb_pkg::FULL_TURN)) begin
         full_c = full_c - 18'(pnpb_pkg::FULL_TURN);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.angle) full_ff <= 17'(full_c);
   end

   // scale to bins, then divide by a full turn through the reciprocal
   logic [pnpb_pkg::N_W-1:0] n_ff;
   logic [63:0]              prod;
   logic [pnpb_pkg::Q_W-1:0] q;
   logic [pnpb_pkg::BIN_W-1:0] idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         n_ff <= pnpb_pkg::N_W'(full_ff * pnpb_pkg::BINS) + pnpb_pkg::ROUND_OFS;
      end
   end

   assign prod = 64'(n_ff) * pnpb_pkg::DIV_M;
   assign q    = pnpb_pkg::Q_W'(prod >> pnpb_pkg::DIV_SH);

   always_ff @(posedge clock) begin
      if (cmd.divide) begin
         idx_ff <= (q == pnpb_pkg::Q_W'(pnpb_pkg::BINS)) ? '0 : pnpb_pkg::BIN_W'(q);
      end
   end

   // clearing pass counter
   logic [pnpb_pkg::BIN_W-1:0] clr_ff;
   logic clr_last;
   assign clr_last = (clr_ff == pnpb_pkg::BIN_W'(pnpb_pkg::BINS - 1));
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_last ? '0 : clr_ff + 1'b1;
      end
   end
   assign status.clr_done = clr_last;

   // bin memory, one write and one registered read port
   pnpb_pkg::entry_type mem [pnpb_pkg::BINS];
   pnpb_pkg::entry_type q_ff, wr_data;
   logic [pnpb_pkg::BIN_W-1:0] rd_addr, wr_addr;
   logic wr_en, keep, in_range_ff;

   assign rd_addr = cmd.bin_read ? pnpb_pkg::BIN_W'(bidx_ff) : idx_ff;

   always_comb begin
      keep = (root_ff >= min_range_ff) && (root_ff <= max_range_ff)
             && (!q_ff.filled || root_ff < q_ff.range);
      if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_en   = cmd.ins_write && keep;
         wr_addr = idx_ff;
         wr_data = '{filled: 1'b1, x: x_ff, y: y_ff, range: root_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.bin_read || cmd.ins_read) q_ff <= mem[rd_addr];
      if (cmd.bin_read) in_range_ff <= (32'(bidx_ff) < 32'(pnpb_pkg::BINS));
   end

   // result, zero for an out of range bin
   always_comb begin
      if (in_range_ff) begin
         rsp.read_x        = q_ff.x;
         rsp.read_y        = q_ff.y;
         rsp.read_distance = q_ff.range;
         rsp.read_valid    = q_ff.filled;
      end else begin
         rsp = '0;
      end
   end

endmodule

### sv/polar_nearest_point_binner.sv
// top level of the polar nearest point binner
// depends on pnpb_pkg, pnpb_ctrl and pnpb_dp
`timescale 1ns / 1ps

// Bins 2-D points by bearing and keeps the nearest point per bin. An item is
// taken when start is high and busy is low; busy then stays high until the
// item is done for an insert, read or clear. An insert keeps busy high through
// a 20-step cordic loop, shared with a 16-step square root, plus squaring,
// load, angle, scaling, divide and a read-modify-write of the bin memory. A
// read's result is on rsp for one cycle with rsp_valid high; the receiver
// cannot stall it.
// A clear, and the pass after reset, write one bin per cycle over all 360
// bins with busy high. Configuration writes through csr_ are taken at any
// time but belong in idle periods.

module polar_nearest_point_binner (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pnpb_pkg::req_type req,
   output logic              rsp_valid,
   output pnpb_pkg::rsp_type rsp,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);

   pnpb_pkg::cmd_type    cmd;
   pnpb_pkg::status_type status;

   // sequencing
   pnpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req.kind),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // arithmetic and storage
   pnpb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp       (rsp)
   );

   // one result cycle per read
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // only read transfers produce results
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req.kind != pnpb_pkg::KIND_READ) |=> !rsp_valid)
      else $error("result after a non-read transfer");

   // a valid item keeps the block busy next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req.kind == pnpb_pkg::KIND_INSERT ||
       req.kind == pnpb_pkg::KIND_READ || req.kind == pnpb_pkg::KIND_CLEAR)) |=> busy)
      else $error("accepted item did not start work");

endmodule

### verif/tb.sv
// testbench for the polar nearest point binner: random and directed points,
// reads and clears checked against a bearing/range bin predictor
// depends on pnpb_pkg and polar_nearest_point_binner
`timescale 1ns / 1ps

module tb;

   localparam int LIMIT = 2000000;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   pnpb_pkg::req_type   req;
   logic                rsp_valid;
   pnpb_pkg::rsp_type   rsp;
   logic                csr_we;
   logic                csr_index;
   logic [15:0]         csr_wdata;

   int unsigned fail_count = 0;
   longint      cycle_count = 0;
   int          reads_seen = 0;
   int          inserts_sent = 0;

   // angle table in 2^-16 degree
   localparam longint ATAN_Q16 [20] = '{2949120, 1740967, 919879, 466945, 234379,
      117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

   // bin store, limits and queue of pending read results
   class bin_scoreboard;
      logic [15:0] sx [pnpb_pkg::BINS];
      logic [15:0] sy [pnpb_pkg::BINS];
      logic [15:0] sr [pnpb_pkg::BINS];
      bit          sf [pnpb_pkg::BINS];
      logic [15:0] lo_mm;
      logic [15:0] hi_mm;
      pnpb_pkg::rsp_type pending_reads [$];

      function void wipe();
         for (int i = 0; i < pnpb_pkg::BINS; i++) begin
            sx[i] = '0; sy[i] = '0; sr[i] = '0; sf[i] = 0;
         end
      endfunction

      function longint fshr(longint v, int s);
         return v >>> s;
      endfunction

      // first-quadrant bearing in 1/256 degree
      function longint quad_bearing(longint ax, longint ay);
         longint cx, cy, z, dx, dy;
         if (ay == 0) return 0;
         if (ax == 0) return pnpb_pkg::QUARTER_TURN;
         cx = ax << pnpb_pkg::PRESHIFT;
         cy = ay << pnpb_pkg::PRESHIFT;
         z = 0;
         for (int i = 0; i < 20; i++) begin
            dx = fshr(cy, i);
            dy = fshr(cx, i);
            if (cy > 0) begin
               cx += dx; cy -= dy; z += ATAN_Q16[i];
            end else begin
               cx -= dx; cy += dy; z -= ATAN_Q16[i];
            end
         end
         if (z < 0) z = 0;
         if (z > pnpb_pkg::Z_MAX) z = pnpb_pkg::Z_MAX;
         return (z + 128) >>> 8;
      endfunction

      function longint root_floor(longint v);
         longint r;
         r = 0;
         for (int b = 15; b >= 0; b--)
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v)
               r += longint'(1) << b;
         return r;
      endfunction

      function void note_input(pnpb_pkg::req_type it);
         longint x, y, ax, ay, a, full, rng, idx;
         case (pnpb_pkg::kind_type'(it.kind))
            pnpb_pkg::KIND_INSERT: begin
               x = it.point_x; y = it.point_y;
               ax = x < 0 ? -x : x;
               ay = y < 0 ? -y : y;
               a = quad_bearing(ax, ay);
               rng = root_floor(ax * ax + ay * ay);
               if (x >= 0 && y >= 0) full = a;
               else if (x < 0 && y >= 0) full = pnpb_pkg::HALF_TURN - a;
               else if (x < 0) full = pnpb_pkg::HALF_TURN + a;
               else full = pnpb_pkg::FULL_TURN - a;
               if (full >= pnpb_pkg::FULL_TURN) full -= pnpb_pkg::FULL_TURN;
               idx = ((full * pnpb_pkg::BINS + pnpb_pkg::HALF_TURN / 2)
                      / pnpb_pkg::FULL_TURN) % pnpb_pkg::BINS;
               if (rng >= lo_mm && rng <= hi_mm && (!sf[idx] || rng < sr[idx])) begin
                  sf[idx] = 1;
                  sx[idx] = it.point_x;
                  sy[idx] = it.point_y;
                  sr[idx] = rng[15:0];
               end
            end
            pnpb_pkg::KIND_CLEAR: wipe();
            pnpb_pkg::KIND_READ: begin
               pnpb_pkg::rsp_type e;
               e = '0;
               if (it.bin_index < pnpb_pkg::BINS) begin
                  e.read_x = sx[it.bin_index];
                  e.read_y = sy[it.bin_index];
                  e.read_distance = sr[it.bin_index];
                  e.read_valid = sf[it.bin_index];
               end
               pending_reads = {pending_reads, e};
            end
            default: ;
         endcase
      endfunction

      function int check_result(pnpb_pkg::rsp_type got);
         pnpb_pkg::rsp_type e;
         int bad;
         bad = 0;
         if (pending_reads.size() == 0) begin
            $error("unexpected read result %p", got);
            return 1;
         end
         e = pending_reads.pop_front();
         if (got.read_x !== e.read_x) begin
            $error("read_x expected %0d actual %0d", e.read_x, got.read_x); bad++;
         end
         if (got.read_y !== e.read_y) begin
            $error("read_y expected %0d actual %0d", e.read_y, got.read_y); bad++;
         end
         if (got.read_distance !== e.read_distance) begin
            $error("read_distance expected %0d actual %0d", e.read_distance,
                   got.read_distance); bad++;
         end
         if (got.read_valid !== e.read_valid) begin
            $error("read_valid expected %0d actual %0d", e.read_valid, got.read_valid);
            bad++;
         end
         return bad;
      endfunction
   endclass

   bin_scoreboard sb;
   bit calm;

   polar_nearest_point_binner u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // result checking and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         fail_count += sb.check_result(rsp);
         reads_seen++;
      end
      if (cycle_count > LIMIT) begin
         $display("polar_nearest_point_binner test failed");
         $finish;
      end
   end

   // start stays high from one transfer to the next unless a gap is taken
   task automatic send(pnpb_pkg::kind_type k, logic signed [15:0] x,
                       logic signed [15:0] y, logic [8:0] b);
      pnpb_pkg::req_type it;
      it.kind = k; it.point_x = x; it.point_y = y; it.bin_index = b;
      // random gap before the transfer, skipped while calm
      while (!calm && $urandom_range(99) < 18) begin
         start <= 0;
         @(posedge clock);
      end
      req <= it;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_input(it);
      if (k == pnpb_pkg::KIND_INSERT) inserts_sent++;
   endtask

   // write a limit once the block has drained
   task automatic set_limit(pnpb_pkg::csr_index_type i, logic [15:0] v);
      start <= 0;
      while (sb.pending_reads.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      while (busy) @(posedge clock);
      csr_we <= 1; csr_index <= i; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      if (i == pnpb_pkg::CSR_MIN_RANGE) sb.lo_mm = v; else sb.hi_mm = v;
   endtask

   task automatic random_item();
      int r;
      logic signed [15:0] x, y;
      r = $urandom_range(99);
      if ($urandom_range(3) == 0) begin
         x = 16'($urandom); y = 16'($urandom);
      end else begin
         x = $signed(16'($urandom_range(12000))) - 16'sd6000;
         y = $signed(16'($urandom_range(12000))) - 16'sd6000;
      end
      if (r < 60) send(pnpb_pkg::KIND_INSERT, x, y, 9'($urandom));
      else if (r < 96) send(pnpb_pkg::KIND_READ, 16'($urandom), 16'($urandom),
                            9'($urandom_range(359)));
      else if (r < 97) send(pnpb_pkg::KIND_READ, 16'($urandom), 16'($urandom),
                            9'($urandom_range(511, 360)));
      else if (r < 98) send(pnpb_pkg::KIND_CLEAR, x, y, 9'($urandom));
      else send(pnpb_pkg::KIND_NONE, x, y, 9'($urandom));
   endtask

   initial begin
      sb = new();
      sb.wipe();
      sb.lo_mm = 100; sb.hi_mm = 5000;
      calm = 0;
      reset = 1; start = 0; req = '0;
      csr_we = 0; csr_index = 0; csr_wdata = '0;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: axes, diagonals, near-axis points, origin, out-of-range read, kind 3, clear
      send(pnpb_pkg::KIND_INSERT, 16'sd1000, 16'sd0, '0);
      send(pnpb_pkg::KIND_INSERT, 16'sd0, 16'sd1000, '0);
      send(pnpb_pkg::KIND_INSERT, -16'sd1000, 16'sd0, '0);
      send(pnpb_pkg::KIND_INSERT, 16'sd0, -16'sd1000, '0);
      send(pnpb_pkg::KIND_INSERT, 16'sd2000, -16'sd2000, '0);
      send(pnpb_pkg::KIND_INSERT, -16'sd700, -16'sd700, '0);
      send(pnpb_pkg::KIND_INSERT, 16'sd1000, -16'sd3, '0);
      send(pnpb_pkg::KIND_INSERT, 16'sd900, 16'sd1, '0);
      send(pnpb_pkg::KIND_INSERT, 16'sd0, 16'sd0, '0);
      send(pnpb_pkg::KIND_NONE, 16'sd500, 16'sd500, 9'd45);
      send(pnpb_pkg::KIND_READ, '0, '0, 9'd0);
      send(pnpb_pkg::KIND_READ, '0, '0, 9'd90);
      send(pnpb_pkg::KIND_READ, '0, '0, 9'd180);
      send(pnpb_pkg::KIND_READ, '0, '0, 9'd270);
      send(pnpb_pkg::KIND_READ, '0, '0, 9'd315);
      send(pnpb_pkg::KIND_READ, '0, '0, 9'd359);
      send(pnpb_pkg::KIND_READ, 16'sd1, 16'sd1, 9'd511);
      send(pnpb_pkg::KIND_CLEAR, '0, '0, '0);
      send(pnpb_pkg::KIND_READ, '0, '0, 9'd0);

      // widest limits: every range passes, tried with extreme points and the origin
      set_limit(pnpb_pkg::CSR_MIN_RANGE, 16'd0);
      set_limit(pnpb_pkg::CSR_MAX_RANGE, 16'hffff);
      send(pnpb_pkg::KIND_INSERT, 16'sh8000, 16'sh8000, '0);
      send(pnpb_pkg::KIND_INSERT, 16'sh7fff, 16'sh8000, '0);
      send(pnpb_pkg::KIND_INSERT, 16'sh8000, 16'sh7fff, '0);
      send(pnpb_pkg::KIND_INSERT, 16'sd0, 16'sd0, '0);
      send(pnpb_pkg::KIND_READ, '0, '0, 9'd225);
      send(pnpb_pkg::KIND_READ, '0, '0, 9'd0);

      // random phases over several limit settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               set_limit(pnpb_pkg::CSR_MIN_RANGE, 16'd100);
               set_limit(pnpb_pkg::CSR_MAX_RANGE, 16'd5000);
            end
            1: begin
               set_limit(pnpb_pkg::CSR_MIN_RANGE, 16'd0);
               set_limit(pnpb_pkg::CSR_MAX_RANGE, 16'd46341);
            end
            2: begin
               set_limit(pnpb_pkg::CSR_MIN_RANGE, 16'd4000);
               set_limit(pnpb_pkg::CSR_MAX_RANGE, 16'd1000);
            end
            3: begin
               set_limit(pnpb_pkg::CSR_MIN_RANGE, 16'($urandom_range(3000)));
               set_limit(pnpb_pkg::CSR_MAX_RANGE, 16'($urandom_range(46341, 3000)));
            end
            default: begin
               set_limit(pnpb_pkg::CSR_MIN_RANGE, 16'd46341);
               set_limit(pnpb_pkg::CSR_MAX_RANGE, 16'hffff);
            end
         endcase
         calm = (ph == 1);
         for (int n = 0; n < 345; n++) random_item();
      end
      calm = 0;
      start <= 0;

      while (sb.pending_reads.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("covered %0d inserts and %0d checked reads over five limit settings",
               inserts_sent, reads_seen);
      if (fail_count == 0 && sb.pending_reads.size() == 0)
         $display("polar_nearest_point_binner test passed");
      else
         $display("polar_nearest_point_binner test failed");
      $finish;
   end

endmodule

### polar_nearest_point_binner.f
sv/pnpb_pkg.sv
sv/pnpb_ctrl.sv
sv/pnpb_dp.sv
sv/polar_nearest_point_binner.sv
verif/tb.sv
